// ===== hdl/simb_pkg.sv =====
// ----------------------------------------------------------------------------
// simb_pkg
// Shared constants and types of the sorted insertion merge buffer.
// ----------------------------------------------------------------------------
package simb_pkg;

    // Default number of sorted slots
    localparam int SIMB_DEPTH = 32;

    // Request command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic ins;        // place the request value in sorted position
        logic pop;        // move the lowest entry to the output, shift the rest down
        logic emit_empty; // emit one empty marker item
        logic clr_flag;   // clear the sticky overflow flag
    } t_simb_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic count_zero;
        logic count_one;
        logic out_free;   // output register can take an item this cycle
    } t_simb_sts;

endpackage

// ===== hdl/simb_if.sv =====
// ----------------------------------------------------------------------------
// simb_if
// Valid/ready channels of the sorted insertion merge buffer.
// ----------------------------------------------------------------------------
interface simb_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [31:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface simb_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value_res;
    logic               last;
    logic               empty_res;
    logic               overflowed;

    modport source (output valid, output value_res, output last, output empty_res,
                    output overflowed, input ready);
    modport sink   (input valid, input value_res, input last, input empty_res,
                    input overflowed, output ready);
endinterface

// ===== hdl/simb_ctrl.sv =====
// ----------------------------------------------------------------------------
// simb_ctrl
// Controller: accepts requests in idle, sequences a flush one item at a time.
// ----------------------------------------------------------------------------
module simb_ctrl
    import simb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_cmd,
    input  t_simb_sts i_sts,
    output logic      o_in_ready,
    output t_simb_cmd o_cmd
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_FLUSH = 1'b1;

    logic r_state;
    logic n_state;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_cmd == CMD_FLUSH) begin
                        n_state = ST_FLUSH;
                    end else begin
                        o_cmd.ins = 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (i_sts.out_free) begin
                    if (i_sts.count_zero) begin
                        o_cmd.emit_empty = 1'b1;
                        o_cmd.clr_flag   = 1'b1;
                        n_state          = ST_IDLE;
                    end else begin
                        o_cmd.pop = 1'b1;
                        if (i_sts.count_one) begin
                            o_cmd.clr_flag = 1'b1;
                            n_state        = ST_IDLE;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hdl/simb_dp.sv =====
// ----------------------------------------------------------------------------
// simb_dp
// Datapath: row of sorted slots with parallel compare, fill count, overflow
// flag and the output register.
// ----------------------------------------------------------------------------
module simb_dp
    import simb_pkg::*;
#(
    parameter int DEPTH = SIMB_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_simb_cmd          i_cmd,
    input  logic signed [31:0] i_value,
    input  logic               i_out_ready,
    output t_simb_sts          o_sts,
    output logic               o_out_valid,
    output logic signed [31:0] o_value_res,
    output logic               o_last,
    output logic               o_empty_res,
    output logic               o_overflowed
);

    localparam int CW = $clog2(DEPTH + 1);

    logic signed [31:0] r_ent [DEPTH];
    logic signed [31:0] n_ent [DEPTH];
    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      n_cnt;
    logic               r_ovf;
    logic               n_ovf;
    logic [DEPTH-1:0]   take;
    logic               full;

    logic               r_ov;
    logic signed [31:0] r_ov_value;
    logic               r_ov_last;
    logic               r_ov_empty;
    logic               r_ov_ovf;

    assign full = (r_cnt == CW'(DEPTH));

    // Slots from the insert position up to the fill count take new data
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            take[i] = ((CW'(i) < r_cnt) && (r_ent[i] > i_value)) || (CW'(i) == r_cnt);
        end
    end

    // Next slot contents: insert shifts up, pop shifts down
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_ent[i] = r_ent[i];
        end
        if (i_cmd.ins) begin
            if (take[0]) begin
                n_ent[0] = i_value;
            end
            for (int i = 1; i < DEPTH; i++) begin
                if (take[i]) begin
                    n_ent[i] = take[i-1] ? r_ent[i-1] : i_value;
                end
            end
        end else if (i_cmd.pop) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                n_ent[i] = r_ent[i+1];
            end
        end
    end

    // Fill count and sticky overflow
    always_comb begin
        n_cnt = r_cnt;
        n_ovf = r_ovf;
        if (i_cmd.ins) begin
            if (full) begin
                n_ovf = 1'b1;
            end else begin
                n_cnt = r_cnt + CW'(1);
            end
        end else if (i_cmd.pop) begin
            n_cnt = r_cnt - CW'(1);
        end
        if (i_cmd.clr_flag) begin
            n_ovf = 1'b0;
        end
    end

    // Slot storage, no reset
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            r_ent[i] <= n_ent[i];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_ovf <= n_ovf;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.pop || i_cmd.emit_empty) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop || i_cmd.emit_empty) begin
            r_ov_value <= i_cmd.pop ? r_ent[0] : 32'sd0;
            r_ov_last  <= i_cmd.pop ? (r_cnt == CW'(1)) : 1'b1;
            r_ov_empty <= i_cmd.emit_empty;
            r_ov_ovf   <= r_ovf;
        end
    end

    assign o_sts.count_zero = (r_cnt == '0);
    assign o_sts.count_one  = (r_cnt == CW'(1));
    assign o_sts.out_free   = !r_ov || i_out_ready;

    assign o_out_valid  = r_ov;
    assign o_value_res  = r_ov_value;
    assign o_last       = r_ov_last;
    assign o_empty_res  = r_ov_empty;
    assign o_overflowed = r_ov_ovf;

endmodule

// ===== hdl/sorted_insertion_merge_buffer.sv =====
// ----------------------------------------------------------------------------
// sorted_insertion_merge_buffer
// Sorted store of signed values with insert and ordered flush requests.
// ----------------------------------------------------------------------------
// Insert: all slots compare against the value at once and shift up in the same
//   cycle; while idle, a new request may follow every cycle.
// Flush: the request passes the state register, then the output register; then
//   one item per cycle unless the output stalls (the slot row shifts down into
//   the output register); the input stays busy until the last item is popped.
// Reset: fill count, overflow flag, controller and output valid clear synchronously.
module sorted_insertion_merge_buffer
    import simb_pkg::*;
#(
    parameter int DEPTH = SIMB_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    simb_in_if.sink    i_in,
    simb_out_if.source o_out
);

    t_simb_cmd cmd;
    t_simb_sts sts;

    // Sequencer
    simb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .i_sts      (sts),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    // Slot row and output stage
    simb_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_value      (i_in.value),
        .i_out_ready  (o_out.ready),
        .o_sts        (sts),
        .o_out_valid  (o_out.valid),
        .o_value_res  (o_out.value_res),
        .o_last       (o_out.last),
        .o_empty_res  (o_out.empty_res),
        .o_overflowed (o_out.overflowed)
    );

    // A flush request blocks new requests in the following cycle
    a_flush_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.cmd == CMD_FLUSH) |=> !i_in.ready)
        else $error("request accepted right after a flush");

    // An empty marker is always the last item of its run
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.empty_res) |-> o_out.last)
        else $error("empty marker without last");

    // An empty marker carries a zero value
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.empty_res) |-> (o_out.value_res == 32'sd0))
        else $error("empty marker with nonzero value");

    // Items leave only while a flush is in progress
    a_no_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.pop || cmd.emit_empty) |-> !i_in.ready)
        else $error("output item produced while idle");

endmodule
